### rtl/tsib_pkg.sv
// package for the timestamp sorted interpolation buffer
// holds sizes, status codes, state enum and the entry record type
`default_nettype none
package tsib_pkg;
    localparam int DEPTH = 64;
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = 32 + 16 + 32 + 32 + 32;

    localparam logic [2:0] ST_INSERTED = 3'd0;
    localparam logic [2:0] ST_EVICTED = 3'd1;
    localparam logic [2:0] ST_DISCARD = 3'd2;
    localparam logic [2:0] ST_HIT = 3'd3;
    localparam logic [2:0] ST_MISS = 3'd4;

    localparam logic REG_CAPACITY = 1'b0;
    localparam logic REG_LAG = 1'b1;

    typedef struct packed {
        logic [31:0] t;
        logic [15:0] owner;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
    } t_entry;

    typedef enum logic [3:0] {
        S_IDLE, S_FIND_RD, S_FIND, S_MOVE_RD, S_MOVE_WR, S_PLACE,
        S_QA_RD, S_QA, S_QB_RD, S_QB, S_DIV, S_MUL, S_OUT
    } t_state;
endpackage
`default_nettype wire

### rtl/timestamp_sorted_interpolation_buffer_core.sv
// timestamp sorted interpolation buffer, top level
// insert finds the slot, then moves entries one at a time (dropping the oldest when full)
// query scans back and then forward for the entity, then runs 48 divide steps unless saturated
// one transaction at a time, set by the single entry memory port and the serial divider
// reset (synchronous, active low) empties the buffer and restores capacity 64, lag 0
// depends on tsib_pkg and tsib_ram
`default_nettype none
module timestamp_sorted_interpolation_buffer_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_kind,
    input  wire logic [31:0] i_stamp,
    input  wire logic [15:0] i_entity_id,
    input  wire logic signed [31:0] i_pos_x,
    input  wire logic signed [31:0] i_pos_y,
    input  wire logic signed [31:0] i_pos_z,
    input  wire logic [31:0] i_now_time,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [2:0]       o_status,
    output logic signed [31:0] o_out_x,
    output logic signed [31:0] o_out_y,
    output logic signed [31:0] o_out_z,
    output logic [6:0]       o_held_count,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);
    import tsib_pkg::*;

    t_state r_state, n_state;
    logic [6:0] r_cap;
    logic [31:0] r_lag;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_idx, n_idx;     // scan / move pointer
    logic [CW-1:0] r_pos, n_pos;     // insert slot
    logic r_evict, n_evict;
    t_entry r_item, n_item;
    logic [31:0] r_now, n_now;
    t_entry r_ea, n_ea, r_eb, n_eb;
    logic [31:0] r_rem, n_rem, r_q, n_q;
    logic [5:0] r_bit, n_bit;
    logic [1:0] r_lane, n_lane;
    logic [31:0] r_res [3];
    logic [31:0] n_res [3];
    logic r_ovalid, n_ovalid;
    logic [2:0] r_ost, n_ost;
    logic out_load;
    logic [2:0] r_out_st;
    logic [31:0] r_out_res [3];
    logic [6:0] r_out_held;

    logic ram_we;
    logic [AW-1:0] ram_wa, ram_ra;
    t_entry ram_wd, ram_rd;

    tsib_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_ram (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(ram_wa), .i_wdata(ram_wd),
        .i_raddr(ram_ra), .o_rdata(ram_rd)
    );

    logic [CW-1:0] cap_eff;
    always_comb begin
        if (r_cap < 7'd2) cap_eff = CW'(2);
        else if (32'(r_cap) > 32'(DEPTH)) cap_eff = CW'(DEPTH);
        else cap_eff = CW'(r_cap);
    end

    logic [31:0] target;
    assign target = (r_now > r_lag) ? r_now - r_lag : 32'd0;

    // interpolation product per lane
    logic [31:0] p0, p1;
    logic signed [32:0] dlt;
    logic signed [50:0] prod;
    always_comb begin
        unique case (r_lane)
            2'd0: begin p0 = r_ea.x; p1 = r_eb.x; end
            2'd1: begin p0 = r_ea.y; p1 = r_eb.y; end
            default: begin p0 = r_ea.z; p1 = r_eb.z; end
        endcase
        dlt = $signed({p1[31], p1}) - $signed({p0[31], p0});
        prod = 51'(dlt) * $signed({35'd0, r_q[15:0]});
    end

    logic [32:0] trial;
    assign trial = {r_rem, r_q[31]} - {1'b0, r_eb.t - r_ea.t};

    always_comb begin
        n_state = r_state; n_count = r_count; n_idx = r_idx; n_pos = r_pos;
        n_evict = r_evict; n_item = r_item; n_now = r_now;
        n_ea = r_ea; n_eb = r_eb; n_rem = r_rem; n_q = r_q; n_bit = r_bit;
        n_lane = r_lane; n_res = r_res; n_ovalid = r_ovalid; n_ost = r_ost;
        ram_we = 1'b0; ram_wa = '0; ram_wd = r_item; ram_ra = '0;
        out_load = 1'b0;
        if (r_ovalid && !i_stall) n_ovalid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_item = '{t: i_stamp, owner: i_entity_id, x: i_pos_x,
                               y: i_pos_y, z: i_pos_z};
                    n_now = i_now_time;
                    n_idx = '0;
                    if (i_kind) begin
                        n_idx = r_count;
                        n_state = S_QA_RD;
                    end else n_state = S_FIND_RD;
                end
            end
            // find first entry with stamp greater than the new one
            S_FIND_RD: begin
                if (r_idx == r_count) begin
                    n_pos = r_idx;
                    n_idx = (r_count < cap_eff) ? r_count : CW'(1);
                    n_state = S_MOVE_RD;
                end else begin
                    ram_ra = r_idx[AW-1:0];
                    n_state = S_FIND;
                end
            end
            S_FIND: begin
                if (ram_rd.t <= r_item.t) begin
                    n_idx = r_idx + 1'b1;
                    n_state = S_FIND_RD;
                end else begin
                    n_pos = r_idx;
                    n_idx = (r_count < cap_eff) ? r_count : CW'(1);
                    n_state = S_MOVE_RD;
                end
            end
            S_MOVE_RD: begin
                n_state = S_MOVE_WR;
                if (r_count < cap_eff) begin
                    n_evict = 1'b0;
                    if (r_idx == r_pos) n_state = S_PLACE;
                    else ram_ra = AW'(r_idx - 1'b1);
                end else if (r_pos == '0) begin
                    n_ost = ST_DISCARD;
                    n_res = '{32'd0, 32'd0, 32'd0};
                    n_state = S_OUT;
                end else begin
                    n_evict = 1'b1;
                    if (r_idx >= r_pos) begin
                        n_pos = r_pos - 1'b1;
                        n_state = S_PLACE;
                    end else ram_ra = r_idx[AW-1:0];
                end
            end
            S_MOVE_WR: begin
                ram_we = 1'b1;
                ram_wd = ram_rd;
                if (r_evict) begin
                    ram_wa = AW'(r_idx - 1'b1);
                    n_idx = r_idx + 1'b1;
                end else begin
                    ram_wa = r_idx[AW-1:0];
                    n_idx = r_idx - 1'b1;
                end
                n_state = S_MOVE_RD;
            end
            S_PLACE: begin
                ram_we = 1'b1;
                ram_wa = r_pos[AW-1:0];
                ram_wd = r_item;
                n_res = '{32'd0, 32'd0, 32'd0};
                if (r_evict) n_ost = ST_EVICTED;
                else begin
                    n_ost = ST_INSERTED;
                    n_count = r_count + 1'b1;
                end
                n_state = S_OUT;
            end
            // backward scan for older entry of the entity
            S_QA_RD: begin
                if (r_idx == '0) begin
                    n_ost = ST_MISS; n_res = '{32'd0, 32'd0, 32'd0};
                    n_state = S_OUT;
                end else begin
                    ram_ra = AW'(r_idx - 1'b1);
                    n_state = S_QA;
                end
            end
            S_QA: begin
                if (ram_rd.t < target && ram_rd.owner == r_item.owner) begin
                    n_ea = ram_rd;
                    n_idx = r_idx;
                    n_state = S_QB_RD;
                end else begin
                    n_idx = r_idx - 1'b1;
                    n_state = S_QA_RD;
                end
            end
            S_QB_RD: begin
                if (r_idx == r_count) begin
                    n_ost = ST_MISS; n_res = '{32'd0, 32'd0, 32'd0};
                    n_state = S_OUT;
                end else begin
                    ram_ra = r_idx[AW-1:0];
                    n_state = S_QB;
                end
            end
            S_QB: begin
                if (ram_rd.owner == r_item.owner) begin
                    n_eb = ram_rd;
                    n_rem = '0;
                    n_q = target - r_ea.t;
                    n_bit = '0;
                    if ((target - r_ea.t) >= (ram_rd.t - r_ea.t)) begin
                        n_q = 32'h0000_FFFF;
                        n_lane = '0;
                        n_state = S_MUL;
                    end else n_state = S_DIV;
                end else begin
                    n_idx = r_idx + 1'b1;
                    n_state = S_QB_RD;
                end
            end
            // restoring division of (num << 16) by den, one bit a cycle
            S_DIV: begin
                if (!trial[32]) begin
                    n_rem = trial[31:0];
                    n_q = {r_q[30:0], 1'b1};
                end else begin
                    n_rem = {r_rem[30:0], r_q[31]};
                    n_q = {r_q[30:0], 1'b0};
                end
                n_bit = r_bit + 1'b1;
                if (r_bit == 6'd47) begin
                    n_lane = '0;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_res[r_lane] = p0 + 32'(prod >>> 16);
                n_lane = r_lane + 1'b1;
                if (r_lane == 2'd2) begin
                    n_ost = ST_HIT;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_ovalid || !i_stall) begin
                    n_ovalid = 1'b1;
                    out_load = 1'b1;
                    n_state = S_IDLE;
                end else n_ost = r_ost;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // quotient register is only 32 bits; the 48 step division keeps low bits
    // since num < den the quotient fits 16 bits, high steps shift in zeros
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_cap <= 7'd64;
            r_lag <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                if (i_cfg_index == REG_CAPACITY) r_cap <= i_cfg_data[6:0];
                else r_lag <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx; r_pos <= n_pos; r_evict <= n_evict;
        r_item <= n_item; r_now <= n_now; r_ea <= n_ea; r_eb <= n_eb;
        r_rem <= n_rem; r_q <= n_q; r_bit <= n_bit; r_lane <= n_lane;
        r_res <= n_res; r_ost <= n_ost;
        // result register keeps the offered transaction steady while stalled
        if (out_load) begin
            r_out_st <= r_ost;
            r_out_res <= r_res;
            r_out_held <= 7'(r_count);
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_ovalid;
    assign o_status = r_out_st;
    assign o_out_x = r_out_res[0];
    assign o_out_y = r_out_res[1];
    assign o_out_z = r_out_res[2];
    assign o_held_count = r_out_held;

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= 32'(DEPTH)) else $error("count above depth");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_state != S_IDLE)) else $error("accept lost");
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status <= ST_MISS)) else $error("bad status");
endmodule
`default_nettype wire

### rtl/tsib_ram.sv
// generic single port write, single port registered read memory
// no dependencies
`default_nettype none
module tsib_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

### bench/testbench.sv
// self-checking bench for timestamp_sorted_interpolation_buffer_core
// queue-fed driver and monitor with an in-bench predictor of the sorted buffer
// depends on tsib_pkg and the core rtl
`default_nettype none
module testbench;
    import tsib_pkg::*;

    localparam int  CYCLE_LIMIT = 5000000;
    localparam int  DRAIN_CYCLES = 250;
    localparam int  HOLD_CYCLES = 2000;
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [31:0] stamp;
        logic [15:0] ent;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [31:0] now;
    } t_request;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [6:0]  held;
    } t_outcome;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_kind = 1'b0;
    logic [31:0] i_stamp = '0;
    logic [15:0] i_entity_id = '0;
    logic signed [31:0] i_pos_x = '0;
    logic signed [31:0] i_pos_y = '0;
    logic signed [31:0] i_pos_z = '0;
    logic [31:0] i_now_time = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [2:0]  o_status;
    logic signed [31:0] o_out_x;
    logic signed [31:0] o_out_y;
    logic signed [31:0] o_out_z;
    logic [6:0]  o_held_count;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = 1'b0;
    logic [31:0] i_cfg_data = '0;

    timestamp_sorted_interpolation_buffer_core DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_kind(i_kind), .i_stamp(i_stamp), .i_entity_id(i_entity_id),
        .i_pos_x(i_pos_x), .i_pos_y(i_pos_y), .i_pos_z(i_pos_z),
        .i_now_time(i_now_time),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_status(o_status), .o_out_x(o_out_x), .o_out_y(o_out_y),
        .o_out_z(o_out_z), .o_held_count(o_held_count),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    t_entry      slots [DEPTH];
    int          held = 0;
    int          cfg_capacity = 64;
    logic [31:0] cfg_lag = '0;

    t_request    pending_q [$];
    t_outcome    outcome_q [$];
    int          errors = 0;
    int          cycles = 0;
    bit          sending = 0;
    int          send_gap = 0;
    int          stall_left = 0;
    int          hold_left = 0;
    bit          hold_kick = 0;
    logic [31:0] t_base = 32'd5000;

    function automatic logic [31:0] blend(logic signed [31:0] p0, logic signed [31:0] p1,
                                          longint unsigned frac);
        longint d;
        longint r;
        d = longint'(p1) - longint'(p0);
        r = longint'(p0) + ((d * longint'(frac)) >>> 16);
        return r[31:0];
    endfunction

    function automatic t_outcome buffer_apply(t_request r);
        int cap;
        int idx;
        int a;
        int b;
        int i;
        int j;
        bit found;
        logic [31:0] target;
        longint unsigned num;
        longint unsigned den;
        longint unsigned frac;
        t_outcome o;
        o = '0;
        cap = cfg_capacity;
        if (cap < 2) cap = 2;
        if (cap > DEPTH) cap = DEPTH;
        if (r.kind == KIND_INSERT) begin
            idx = 0;
            while (idx < held && slots[idx].t <= r.stamp) idx++;
            if (held < cap) begin
                for (i = held; i > idx; i--) slots[i] = slots[i-1];
                held++;
                o.status = ST_INSERTED;
            end else if (idx == 0) begin
                o.status = ST_DISCARD;
            end else begin
                // full: drop the oldest and slide the older part down
                for (i = 1; i < idx; i++) slots[i-1] = slots[i];
                idx--;
                o.status = ST_EVICTED;
            end
            if (o.status != ST_DISCARD) begin
                slots[idx].t = r.stamp;
                slots[idx].owner = r.ent;
                slots[idx].x = r.x;
                slots[idx].y = r.y;
                slots[idx].z = r.z;
            end
        end else begin
            target = (r.now > cfg_lag) ? r.now - cfg_lag : 32'd0;
            o.status = ST_MISS;
            found = 0;
            a = 0;
            b = 0;
            for (i = held; i > 0; i--) begin
                if (slots[i-1].t < target && slots[i-1].owner == r.ent) begin
                    a = i - 1;
                    for (j = a + 1; j < held; j++) begin
                        if (slots[j].owner == r.ent) begin
                            b = j;
                            found = 1;
                            break;
                        end
                    end
                    break;
                end
            end
            if (found) begin
                num = 64'(target - slots[a].t);
                den = 64'(slots[b].t - slots[a].t);
                frac = (num >= den) ? 64'hFFFF : (num << 16) / den;
                o.x = blend(slots[a].x, slots[b].x, frac);
                o.y = blend(slots[a].y, slots[b].y, frac);
                o.z = blend(slots[a].z, slots[b].z, frac);
                o.status = ST_HIT;
            end
        end
        o.held = held[6:0];
        return o;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] want, logic [31:0] got);
        errors++;
        $display("mismatch on %s at cycle %0d: expected %h, got %h", field, cycles, want, got);
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(1, 4);
        return $urandom_range(10, 40);
    endfunction

    // driver: payload held until the transaction is taken
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                outcome_q.push_back(buffer_apply({i_kind, i_stamp, i_entity_id, i_pos_x,
                                                  i_pos_y, i_pos_z, i_now_time}));
                sending = 0;
                send_gap = pick_gap();
            end
            if (!sending) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_valid <= 1'b0;
                end else if (pending_q.size() > 0) begin
                    t_request r;
                    r = pending_q.pop_front();
                    i_kind <= r.kind;
                    i_stamp <= r.stamp;
                    i_entity_id <= r.ent;
                    i_pos_x <= r.x;
                    i_pos_y <= r.y;
                    i_pos_z <= r.z;
                    i_now_time <= r.now;
                    i_valid <= 1'b1;
                    sending = 1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // receiver stall, with one long hold-off on request
    always @(posedge i_clk) begin
        if (hold_kick) begin
            hold_kick = 0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else begin
            stall_left = pick_gap();
            i_stall <= (stall_left > 0);
            if (stall_left > 0) stall_left--;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (outcome_q.size() == 0) begin
                errors++;
                $display("unexpected result transaction at cycle %0d", cycles);
            end else begin
                t_outcome e;
                e = outcome_q.pop_front();
                if (o_status !== e.status) report_mismatch("status", 32'(e.status), 32'(o_status));
                if (o_out_x !== e.x) report_mismatch("out_x", e.x, o_out_x);
                if (o_out_y !== e.y) report_mismatch("out_y", e.y, o_out_y);
                if (o_out_z !== e.z) report_mismatch("out_z", e.z, o_out_z);
                if (o_held_count !== e.held)
                    report_mismatch("held_count", 32'(e.held), 32'(o_held_count));
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic push_insert(logic [31:0] stamp, logic [15:0] ent, logic [31:0] x,
                               logic [31:0] y, logic [31:0] z);
        pending_q.push_back({KIND_INSERT, stamp, ent, x, y, z, $urandom()});
    endtask

    task automatic push_query(logic [15:0] ent, logic [31:0] now);
        pending_q.push_back({KIND_QUERY, $urandom(), ent, $urandom(), $urandom(), $urandom(),
                             now});
    endtask

    task automatic wait_drained();
        while (pending_q.size() > 0 || sending || outcome_q.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_CAPACITY) cfg_capacity = int'(val[6:0]);
        else cfg_lag = val;
    endtask

    // mostly a few entities with stamps near a moving time base, some pure noise
    task automatic push_random(int count);
        int n;
        logic [31:0] lag_part;
        logic [15:0] ent;
        for (n = 0; n < count; n++) begin
            t_base = t_base + $urandom_range(0, 8);
            ent = 16'h0100 + 16'($urandom_range(0, 3));
            lag_part = (cfg_lag > 1000) ? 32'd0 : cfg_lag;
            if ($urandom_range(0, 99) < 15) begin
                pending_q.push_back({$urandom_range(0, 1) == 1 ? KIND_QUERY : KIND_INSERT,
                                     $urandom(), 16'($urandom()), $urandom(), $urandom(),
                                     $urandom(), $urandom()});
            end else if ($urandom_range(0, 99) < 55) begin
                push_insert(t_base - 32'($urandom_range(0, 24)), ent, $urandom(), $urandom(),
                            $urandom());
            end else begin
                push_query(ent, t_base + lag_part + 32'($urandom_range(0, 40)) - 32'd25);
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, equal stamps, saturation, misses
        push_query(16'd7, 32'd0);
        push_insert(32'd1000, 16'd7, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        push_insert(32'd1010, 16'd7, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000);
        push_insert(32'd1010, 16'd9, 32'hFFFF_FFFF, 32'h1234_5678, 32'h8000_0000);
        push_insert(32'd1020, 16'd7, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_0000);
        push_query(16'd7, 32'd1005);
        push_query(16'd7, 32'd1013);
        push_query(16'd7, 32'd1020);
        push_query(16'd7, 32'd1000);
        push_query(16'd7, 32'd2000);
        push_query(16'd9, 32'd1015);
        push_insert(32'd0, 16'd3, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        push_insert(32'hFFFF_FFFF, 16'd3, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        push_query(16'd3, 32'hFFFF_FFFF);
        push_query(16'd3, 32'hFFFF_FFFE);
        push_query(16'd3, 32'd0);
        push_insert(32'd1030, 16'hFFFF, 32'h0000_FFFF, 32'hFFFF_0001, 32'd5);
        push_insert(32'd1030, 16'hFFFF, 32'hFFFF_0000, 32'h0000_0001, 32'd9);
        push_insert(32'd1040, 16'hFFFF, 32'h0001_0000, 32'hFFFF_FFFF, 32'd1);
        push_query(16'hFFFF, 32'd1035);
        push_query(16'hFFFF, 32'd1031);
        wait_drained();

        write_reg(REG_LAG, 32'd5);
        push_query(16'd7, 32'd1018);
        push_query(16'd7, 32'd3);
        wait_drained();

        write_reg(REG_CAPACITY, 32'd64);
        write_reg(REG_LAG, 32'd0);
        hold_kick = 1;
        push_random(260);
        wait_drained();

        write_reg(REG_CAPACITY, 32'd10);
        write_reg(REG_LAG, 32'd100);
        push_random(220);
        wait_drained();

        write_reg(REG_CAPACITY, 32'd0);
        write_reg(REG_LAG, 32'd3);
        push_random(160);
        wait_drained();

        write_reg(REG_CAPACITY, 32'd1);
        push_random(120);
        wait_drained();

        write_reg(REG_CAPACITY, 32'd127);
        write_reg(REG_LAG, 32'hFFFF_FFFF);
        push_random(120);
        wait_drained();

        write_reg(REG_CAPACITY, 32'd2);
        write_reg(REG_LAG, 32'd0);
        push_random(140);
        wait_drained();

        write_reg(REG_CAPACITY, 32'($urandom_range(3, 40)));
        write_reg(REG_LAG, 32'($urandom_range(0, 60)));
        push_random(400);
        wait_drained();

        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
`default_nettype wire

### sim.f
rtl/tsib_pkg.sv
rtl/tsib_ram.sv
rtl/timestamp_sorted_interpolation_buffer_core.sv
bench/testbench.sv
